>>> rtl/core/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants of the ball-plate PD controller
// Beat payloads, controller/datapath command and status, fixed-point constants.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int POS_W  = 12;
  localparam int MS_W   = 10;
  localparam int MID_W  = 12;
  localparam int PWM_W  = 12;
  localparam int T_W    = MS_W + 1;
  localparam int DEN_W  = T_W + 3;
  localparam int NUM_W  = 28;
  localparam int CNT_W  = $clog2(NUM_W);
  localparam int D_W    = 16;
  localparam int ACC_W  = 18;
  localparam int SUM_W  = 7;

  // |e|/25 as multiply by reciprocal
  localparam int RECIP_S   = POS_W + 5;
  localparam int RECIP_K   = (2**RECIP_S + 24) / 25;
  localparam int RECIP_K_W = POS_W + 1;
  localparam int RM_W      = POS_W + RECIP_K_W;
  localparam int Q25_W     = RM_W - RECIP_S;

  localparam int STUCK_X      = 505;
  localparam int NEAR_LIM     = 20;
  localparam int TREND_MARGIN = 15;
  localparam int SKIP_LIM     = 40;
  localparam int BAND         = 50;
  localparam int P_OFFSET     = 4;
  localparam int SUM_HI       = 20;
  localparam int SUM_HI_OUT   = 25;
  localparam int SUM_LO       = -20;
  localparam int MID_RESET    = 307;
  localparam int PWM_MAX      = 4095;

  typedef struct packed {
    logic [POS_W-1:0] sample_x;
    logic [POS_W-1:0] sample_y;
    logic [POS_W-1:0] target_y;
    logic [MS_W-1:0]  elapsed_ms;
  } bpc_in_t;

  typedef struct packed {
    logic             updated;
    logic [PWM_W-1:0] pwm_zero;
    logic [PWM_W-1:0] pwm_one;
    logic [PWM_W-1:0] pwm_two;
    logic [PWM_W-1:0] pwm_three;
  } bpc_out_t;

  typedef logic [3:0][MID_W-1:0] bpc_mids_t;

  typedef struct packed {
    logic load;
    logic classify;
    logic prep;
    logic div1_start;
    logic div1_take;
    logic mult;
    logic div2_start;
    logic sum_take;
    logic out_load;
    logic out_upd;
  } bpc_cmd_t;

  typedef struct packed {
    logic stuck;
    logic plausible;
    logic skip;
    logic in_band;
    logic div_done;
  } bpc_sts_t;

  function automatic logic is_near(logic [POS_W-1:0] a, logic [POS_W-1:0] b, int lim);
    logic [POS_W-1:0] diff;
    diff = (a >= b) ? a - b : b - a;
    return 32'(diff) <= lim;
  endfunction

  function automatic logic trend_ok(logic [POS_W-1:0] a, logic [POS_W-1:0] b,
                                    logic [POS_W-1:0] c);
    logic [POS_W:0] ae;
    logic [POS_W:0] be;
    logic [POS_W:0] ce;
    logic [POS_W:0] m;
    ae = {1'b0, a};
    be = {1'b0, b};
    ce = {1'b0, c};
    m  = (POS_W+1)'(TREND_MARGIN);
    return ((ce < be + m) && (be < ae + m)) || ((ce + m > be) && (be + m > ae));
  endfunction

  function automatic logic [PWM_W-1:0] clamp_pwm(logic signed [MID_W+1:0] v);
    logic [PWM_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > PWM_MAX) begin
      r = PWM_W'(PWM_MAX);
    end else begin
      r = v[PWM_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/bpc_divider.sv
// ----------------------------------------------------------------------------
// bpc_divider: unsigned restoring divider, one quotient bit per cycle
// Quotient valid with the done pulse and held until the next start.
// ----------------------------------------------------------------------------
module bpc_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bpc_pkg::NUM_W-1:0]  num,
  input  logic [bpc_pkg::DEN_W-1:0]  den,
  output logic                       done,
  output logic [bpc_pkg::NUM_W-1:0]  quo
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [bpc_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [bpc_pkg::NUM_W-1:0]   num_r, num_nxt;
  logic [bpc_pkg::DEN_W-1:0]   den_r, den_nxt;
  logic [bpc_pkg::DEN_W-1:0]   rem_r, rem_nxt;
  logic [bpc_pkg::DEN_W:0]     trial;
  logic                        fits;

  assign trial = {rem_r, num_r[bpc_pkg::NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = fits ? bpc_pkg::DEN_W'(trial - {1'b0, den_r})
                     : trial[bpc_pkg::DEN_W-1:0];
      num_nxt = {num_r[bpc_pkg::NUM_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == bpc_pkg::CNT_W'(bpc_pkg::NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

>>> rtl/core/bpc_datapath.sv
// ----------------------------------------------------------------------------
// bpc_datapath: position history, sample checks, PD arithmetic, result register
// Driven step by step by the controller through bpc_cmd_t.
// ----------------------------------------------------------------------------
module bpc_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  bpc_pkg::bpc_cmd_t   cmd,
  output bpc_pkg::bpc_sts_t   sts,
  input  bpc_pkg::bpc_in_t    in_data,
  input  bpc_pkg::bpc_mids_t  mids,
  output bpc_pkg::bpc_out_t   res
);

  localparam int PW = bpc_pkg::POS_W;

  logic [2:0][PW-1:0]                 hx_r, hy_r;
  logic [PW-1:0]                      tgt_r;
  logic [bpc_pkg::MS_W-1:0]           ms_r;
  logic [bpc_pkg::T_W-1:0]            t_r;
  logic [bpc_pkg::DEN_W-1:0]          den5_r;
  logic                               e_pos_r;
  logic                               band_r;
  logic [bpc_pkg::RM_W-1:0]           mul_r;
  logic signed [PW:0]                 d0_r, d1_r;
  logic signed [bpc_pkg::D_W-1:0]     d_r;
  logic signed [bpc_pkg::NUM_W-1:0]   prod_r;
  logic                               n_neg_r;
  logic signed [bpc_pkg::SUM_W-1:0]   sum_r;
  bpc_pkg::bpc_out_t                  res_r;

  logic signed [PW:0]                 e;
  logic [PW:0]                        abs_e;
  logic                               band;
  logic [PW:0]                        mag0;
  logic [bpc_pkg::NUM_W-1:0]          num1;
  logic signed [bpc_pkg::D_W-1:0]     q_s;
  logic signed [bpc_pkg::D_W-1:0]     d_first;
  logic signed [bpc_pkg::D_W-1:0]     d_second;
  logic signed [bpc_pkg::DEN_W+bpc_pkg::D_W:0] prod_full;
  logic signed [bpc_pkg::NUM_W-1:0]   d1x;
  logic signed [bpc_pkg::NUM_W-1:0]   n;
  logic [bpc_pkg::NUM_W-1:0]          n_mag;
  logic [bpc_pkg::Q25_W-1:0]          q25;
  logic signed [bpc_pkg::ACC_W-1:0]   p_s;
  logic signed [bpc_pkg::ACC_W-1:0]   acc;
  logic signed [bpc_pkg::SUM_W-1:0]   sum_c;
  logic signed [bpc_pkg::MID_W+1:0]   sum_x;
  logic                               div_start;
  logic [bpc_pkg::NUM_W-1:0]          div_num;
  logic [bpc_pkg::DEN_W-1:0]          div_den;
  logic                               div_done;
  logic [bpc_pkg::NUM_W-1:0]          div_quo;

  // sample checks
  always_comb begin
    sts.stuck = (hx_r[0] == '0) || (32'(hx_r[0]) == bpc_pkg::STUCK_X) ||
                (hy_r[0] == '0) || (ms_r <= bpc_pkg::MS_W'(1));
    sts.plausible = bpc_pkg::is_near(hx_r[0], hx_r[1], bpc_pkg::NEAR_LIM) &&
                    bpc_pkg::is_near(hy_r[0], hy_r[1], bpc_pkg::NEAR_LIM) &&
                    bpc_pkg::trend_ok(hx_r[0], hx_r[1], hx_r[2]) &&
                    bpc_pkg::trend_ok(hy_r[0], hy_r[1], hy_r[2]);
    sts.skip = bpc_pkg::is_near(hx_r[0], hx_r[2], bpc_pkg::SKIP_LIM) &&
               bpc_pkg::is_near(hy_r[0], hy_r[2], bpc_pkg::SKIP_LIM);
    sts.in_band  = band;
    sts.div_done = div_done;
  end

  // error, its magnitude and band
  assign e     = signed'({1'b0, hy_r[0]}) - signed'({1'b0, tgt_r});
  assign abs_e = (e < 0) ? -e : e;
  assign band  = (e > -bpc_pkg::BAND) && (e < bpc_pkg::BAND);

  // first division: |4*d0| / t
  assign mag0    = (d0_r < 0) ? -d0_r : d0_r;
  assign num1    = bpc_pkg::NUM_W'({mag0[PW-1:0], 2'b00});
  assign q_s     = signed'(div_quo[bpc_pkg::D_W-1:0]);
  assign d_first = (d0_r > 0) ? -q_s : q_s;

  // second division: |5*t*d - 14*d1| / (5*t)
  assign prod_full = signed'({1'b0, den5_r}) * d_r;
  assign d1x       = bpc_pkg::NUM_W'(d1_r);
  assign n         = prod_r - ((d1x <<< 4) - (d1x <<< 1));
  assign n_mag     = (n < 0) ? -n : n;
  assign d_second  = n_neg_r ? -q_s : q_s;

  assign div_start = cmd.div1_start | cmd.div2_start;
  assign div_num   = cmd.div2_start ? n_mag : num1;
  assign div_den   = cmd.div2_start ? den5_r : bpc_pkg::DEN_W'(t_r);

  bpc_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // P + D and clamp
  always_comb begin
    q25 = mul_r[bpc_pkg::RM_W-1:bpc_pkg::RECIP_S];
    if (e_pos_r) begin
      p_s = bpc_pkg::ACC_W'(bpc_pkg::P_OFFSET) + bpc_pkg::ACC_W'(q25);
    end else begin
      p_s = -bpc_pkg::ACC_W'(bpc_pkg::P_OFFSET) - bpc_pkg::ACC_W'(q25);
    end
    acc = p_s + (band_r ? bpc_pkg::ACC_W'(d_second) : bpc_pkg::ACC_W'(0));
    if (acc > bpc_pkg::SUM_HI) begin
      sum_c = bpc_pkg::SUM_W'(bpc_pkg::SUM_HI_OUT);
    end else if (acc < bpc_pkg::SUM_LO) begin
      sum_c = bpc_pkg::SUM_W'(bpc_pkg::SUM_LO);
    end else begin
      sum_c = acc[bpc_pkg::SUM_W-1:0];
    end
  end

  assign sum_x = (bpc_pkg::MID_W+2)'(sum_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hx_r <= '0;
      hy_r <= '0;
    end else if (cmd.load) begin
      hx_r <= {hx_r[1], hx_r[0], in_data.sample_x};
      hy_r <= {hy_r[1], hy_r[0], in_data.sample_y};
    end else if (cmd.classify && !sts.plausible) begin
      hx_r[0] <= hx_r[1];
      hy_r[0] <= hy_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tgt_r <= in_data.target_y;
      ms_r  <= in_data.elapsed_ms;
    end
    if (cmd.classify) begin
      t_r <= sts.plausible ? bpc_pkg::T_W'(ms_r) : {ms_r, 1'b0};
    end
    if (cmd.prep) begin
      den5_r  <= bpc_pkg::DEN_W'({t_r, 2'b00}) + bpc_pkg::DEN_W'(t_r);
      e_pos_r <= e > 0;
      band_r  <= band;
      mul_r   <= bpc_pkg::RM_W'(abs_e[PW-1:0]) * bpc_pkg::RM_W'(bpc_pkg::RECIP_K);
      d0_r    <= signed'({1'b0, hy_r[1]}) - signed'({1'b0, hy_r[0]});
      d1_r    <= signed'({1'b0, hy_r[2]}) - signed'({1'b0, hy_r[1]});
    end
    if (cmd.div1_take) begin
      d_r <= d_first;
    end
    if (cmd.mult) begin
      prod_r <= prod_full[bpc_pkg::NUM_W-1:0];
    end
    if (cmd.div2_start) begin
      n_neg_r <= n < 0;
    end
    if (cmd.sum_take) begin
      sum_r <= sum_c;
    end
    if (cmd.out_load) begin
      if (cmd.out_upd) begin
        res_r.updated   <= 1'b1;
        res_r.pwm_zero  <= bpc_pkg::clamp_pwm(signed'({2'b00, mids[0]}) - sum_x);
        res_r.pwm_one   <= bpc_pkg::clamp_pwm(signed'({2'b00, mids[1]}) + sum_x);
        res_r.pwm_two   <= mids[2];
        res_r.pwm_three <= mids[3];
      end else begin
        res_r <= '0;
      end
    end
  end

  assign res = res_r;

endmodule

>>> rtl/core/bpc_ctrl.sv
// ----------------------------------------------------------------------------
// bpc_ctrl: sequencer of the PD step and owner of the beat handshakes
// One item at a time; the result register is freed by the output handshake.
// ----------------------------------------------------------------------------
module bpc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  bpc_pkg::bpc_sts_t  sts,
  output bpc_pkg::bpc_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_PREP   = 4'd2;
  localparam logic [3:0] S_D1GO   = 4'd3;
  localparam logic [3:0] S_D1WAIT = 4'd4;
  localparam logic [3:0] S_MULT   = 4'd5;
  localparam logic [3:0] S_D2GO   = 4'd6;
  localparam logic [3:0] S_D2WAIT = 4'd7;
  localparam logic [3:0] S_SUM    = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       upd_r, upd_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    upd_nxt       = upd_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_ready      = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.stuck || (!sts.plausible && !sts.skip)) begin
          upd_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else begin
          cmd.classify = 1'b1;
          upd_nxt      = 1'b1;
          state_nxt    = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = sts.in_band ? S_D1GO : S_SUM;
      end
      S_D1GO: begin
        cmd.div1_start = 1'b1;
        state_nxt      = S_D1WAIT;
      end
      S_D1WAIT: begin
        if (sts.div_done) begin
          cmd.div1_take = 1'b1;
          state_nxt     = S_MULT;
        end
      end
      S_MULT: begin
        cmd.mult  = 1'b1;
        state_nxt = S_D2GO;
      end
      S_D2GO: begin
        cmd.div2_start = 1'b1;
        state_nxt      = S_D2WAIT;
      end
      S_D2WAIT: begin
        if (sts.div_done) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum_take = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          cmd.out_upd   = upd_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      upd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      upd_r       <= upd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/core/ball_plate_pd_axis_controller_core.sv
// ----------------------------------------------------------------------------
// ball_plate_pd_axis_controller_core: Y-axis PD controller for a ball plate
// Touch sample in, four servo PWM drives out; APB registers hold the centres.
//
//   channel | ports                             | payload
//   --------+-----------------------------------+------------------------
//   input   | in_valid / in_ready / in_data     | bpc_in_t
//   result  | out_valid / out_ready / out_data  | bpc_out_t
//   config  | psel penable pwrite paddr pwdata  | mid_channel_zero..three
//           | prdata pready                     | at byte 4*i
//
// Stuck or rejected samples go from the check state straight to the result.
// PD step near the target: two 28-step serial divides.
// PD step outside the band: no divides.
// Next beat is taken while a result waits; a stalled result holds the step.
// Synchronous active-low reset clears history, centres to 307, no beat held.
// ----------------------------------------------------------------------------
module ball_plate_pd_axis_controller_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bpc_pkg::bpc_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bpc_pkg::bpc_out_t  out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  bpc_pkg::bpc_mids_t mid_r, mid_nxt;
  bpc_pkg::bpc_cmd_t  cmd;
  bpc_pkg::bpc_sts_t  sts;

  assign pready = 1'b1;
  assign prdata = 32'(mid_r[paddr[3:2]]);

  always_comb begin
    mid_nxt = mid_r;
    if (psel && penable && pwrite) begin
      mid_nxt[paddr[3:2]] = pwdata[bpc_pkg::MID_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r <= {4{bpc_pkg::MID_W'(bpc_pkg::MID_RESET)}};
    end else begin
      mid_r <= mid_nxt;
    end
  end

  bpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bpc_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sts     (sts),
    .in_data (in_data),
    .mids    (mid_r),
    .res     (out_data)
  );

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the ball-plate PD axis controller core
// Touch samples go in as valid/ready beats, a local PD predictor tracks the
// position history and centre registers, and each result beat is compared
// field by field. Centres are rewritten over APB between idle phases.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {
    MID_ZERO  = 0,
    MID_ONE   = 1,
    MID_TWO   = 2,
    MID_THREE = 3
  } mid_reg_t;

  localparam int E_DIV = 25;
  localparam int SETTLE_CYCLES = 80;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  bpc_pkg::bpc_in_t   in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  bpc_pkg::bpc_out_t  out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  bpc_pkg::bpc_in_t          beats_pending[$];
  bpc_pkg::bpc_out_t         pwm_expected[$];
  logic [bpc_pkg::POS_W-1:0] hist_x[3] = '{default: '0};
  logic [bpc_pkg::POS_W-1:0] hist_y[3] = '{default: '0};
  logic [bpc_pkg::MID_W-1:0] mid_set[4] = '{default: bpc_pkg::MID_W'(bpc_pkg::MID_RESET)};
  int                        send_gap_pct = 0;
  int                        recv_gap_pct = 0;
  int                        fail_count = 0;
  int                        walk_x = 2048;
  int                        walk_y = 2048;

  ball_plate_pd_axis_controller_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  function automatic bit close_to(longint a, longint b, longint lim);
    return (a - b <= lim) && (b - a <= lim);
  endfunction

  // a is the newest entry
  function automatic bit trend_good(longint a, longint b, longint c);
    return ((c < b + bpc_pkg::TREND_MARGIN) && (b < a + bpc_pkg::TREND_MARGIN)) ||
           ((c > b - bpc_pkg::TREND_MARGIN) && (b > a - bpc_pkg::TREND_MARGIN));
  endfunction

  function automatic logic [bpc_pkg::PWM_W-1:0] saturate(longint v);
    if (v < 0) begin
      return '0;
    end
    if (v > bpc_pkg::PWM_MAX) begin
      return bpc_pkg::PWM_W'(bpc_pkg::PWM_MAX);
    end
    return v[bpc_pkg::PWM_W-1:0];
  endfunction

  function automatic bpc_pkg::bpc_out_t pd_predict(bpc_pkg::bpc_in_t beat);
    bpc_pkg::bpc_out_t r;
    longint x0, x1, x2, y0, y1, y2, tgt, t, e, p, d, s, m;
    r = '0;
    hist_x[2] = hist_x[1];
    hist_x[1] = hist_x[0];
    hist_x[0] = beat.sample_x;
    hist_y[2] = hist_y[1];
    hist_y[1] = hist_y[0];
    hist_y[0] = beat.sample_y;
    if (beat.sample_x == 0 || beat.sample_x == bpc_pkg::STUCK_X ||
        beat.sample_y == 0 || beat.elapsed_ms <= 1) begin
      return r;
    end
    x0 = hist_x[0]; x1 = hist_x[1]; x2 = hist_x[2];
    y0 = hist_y[0]; y1 = hist_y[1]; y2 = hist_y[2];
    t = beat.elapsed_ms;
    if (close_to(x0, x1, bpc_pkg::NEAR_LIM) && close_to(y0, y1, bpc_pkg::NEAR_LIM) &&
        trend_good(x0, x1, x2) && trend_good(y0, y1, y2)) begin
      t = beat.elapsed_ms;
    end else if (close_to(x0, x2, bpc_pkg::SKIP_LIM) &&
                 close_to(y0, y2, bpc_pkg::SKIP_LIM)) begin
      hist_x[0] = hist_x[1];
      hist_y[0] = hist_y[1];
      y0 = y1;
      t = 2 * t;
    end else begin
      return r;
    end
    tgt = beat.target_y;
    e = y0 - tgt;
    p = ((e > 0) ? bpc_pkg::P_OFFSET : -bpc_pkg::P_OFFSET) + e / E_DIV;
    d = 0;
    if (y0 < tgt + bpc_pkg::BAND && y0 > tgt - bpc_pkg::BAND) begin
      d = (-4 * (y1 - y0)) / t;
      d = (5 * t * d - 14 * (y2 - y1)) / (5 * t);
    end
    s = p + d;
    if (s > bpc_pkg::SUM_HI) begin
      s = bpc_pkg::SUM_HI_OUT;
    end else if (s < bpc_pkg::SUM_LO) begin
      s = bpc_pkg::SUM_LO;
    end
    r.updated = 1'b1;
    m = mid_set[MID_ZERO];
    r.pwm_zero = saturate(m - s);
    m = mid_set[MID_ONE];
    r.pwm_one = saturate(m + s);
    m = mid_set[MID_TWO];
    r.pwm_two = saturate(m);
    m = mid_set[MID_THREE];
    r.pwm_three = saturate(m);
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pwm_expected.push_back(pd_predict(in_data));
      end
      if (!in_valid || in_ready) begin
        if (beats_pending.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          in_data  <= beats_pending.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : result_mon
    bpc_pkg::bpc_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pwm_expected.size() == 0) begin
          $error("result beat with nothing expected: %h", out_data);
          fail_count++;
        end else begin
          want = pwm_expected.pop_front();
          check_field("updated", want.updated, out_data.updated);
          check_field("pwm_zero", want.pwm_zero, out_data.pwm_zero);
          check_field("pwm_one", want.pwm_one, out_data.pwm_one);
          check_field("pwm_two", want.pwm_two, out_data.pwm_two);
          check_field("pwm_three", want.pwm_three, out_data.pwm_three);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  task automatic apb_write(mid_reg_t idx, logic [bpc_pkg::MID_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(4 * idx);
    pwdata  <= {20'($urandom()), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    mid_set[idx] = val;
  endtask

  task automatic set_mids(int m0, int m1, int m2, int m3);
    apb_write(MID_ZERO, bpc_pkg::MID_W'(m0));
    apb_write(MID_ONE, bpc_pkg::MID_W'(m1));
    apb_write(MID_TWO, bpc_pkg::MID_W'(m2));
    apb_write(MID_THREE, bpc_pkg::MID_W'(m3));
  endtask

  task automatic push_beat(int x, int y, int tgt, int ms);
    bpc_pkg::bpc_in_t b;
    b.sample_x   = bpc_pkg::POS_W'(x);
    b.sample_y   = bpc_pkg::POS_W'(y);
    b.target_y   = bpc_pkg::POS_W'(tgt);
    b.elapsed_ms = bpc_pkg::MS_W'(ms);
    beats_pending.push_back(b);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (beats_pending.size() != 0 || in_valid || pwm_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // ball wandering over the plate, with jumps, stuck readings and noise
  task automatic queue_walk(int n);
    int kind, mag, ms, tgt;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(99);
      mag  = $urandom_range(32) + 13;
      if (kind < 70) begin
        walk_x = clip(walk_x + int'($urandom_range(24)) - 12, 1, 4095);
        walk_y = clip(walk_y + int'($urandom_range(24)) - 12, 1, 4095);
      end else if (kind < 80) begin
        walk_x = clip(walk_x + ($urandom_range(1) ? mag : -mag), 1, 4095);
        walk_y = clip(walk_y + int'($urandom_range(90)) - 45, 1, 4095);
      end else if (kind < 88) begin
        walk_x = $urandom_range(4095, 1);
        walk_y = $urandom_range(4095, 1);
      end
      ms = $urandom_range(99);
      if (ms < 85) begin
        ms = $urandom_range(40, 2);
      end else if (ms < 95) begin
        ms = $urandom_range(1023);
      end else begin
        ms = $urandom_range(1);
      end
      tgt = ($urandom_range(99) < 65) ?
            clip(walk_y + int'($urandom_range(140)) - 70, 0, 4095) :
            int'($urandom_range(4095));
      if (kind >= 93) begin
        push_beat($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                  $urandom_range(1023));
      end else if (kind >= 88) begin
        case ($urandom_range(2))
          0: push_beat(0, walk_y, tgt, ms);
          1: push_beat(bpc_pkg::STUCK_X, walk_y, tgt, ms);
          default: push_beat(walk_x, 0, tgt, ms);
        endcase
      end else begin
        push_beat(walk_x, walk_y, tgt, ms);
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_gap_pct = 38;
    recv_gap_pct = 73;
    push_beat(0, 100, 100, 10);
    push_beat(bpc_pkg::STUCK_X, 100, 100, 10);
    push_beat(100, 0, 100, 10);
    push_beat(100, 100, 100, 0);
    push_beat(100, 100, 100, 1);
    push_beat(100, 100, 100, 2);
    push_beat(101, 102, 100, 10);
    push_beat(102, 104, 100, 1023);
    push_beat(120, 124, 100, 7);
    push_beat(100, 104, 100, 7);
    push_beat(300, 300, 300, 5);
    push_beat(110, 110, 100, 5);
    push_beat(4095, 4095, 4095, 1023);
    push_beat(4095, 4095, 0, 1023);
    push_beat(4094, 4094, 4095, 1023);
    push_beat(4095, 4095, 4095, 1023);
    push_beat(4095, 4080, 4095, 2);
    push_beat(1, 1, 4095, 2);
    push_beat(2, 2, 4095, 2);
    push_beat(3, 3, 4095, 2);
    push_beat(4, 5, 0, 3);
    push_beat(2048, 2048, 2047, 1023);
    push_beat(2050, 2060, 2100, 2);
    push_beat(2052, 2075, 2100, 2);
    wait_drained();

    for (int blk = 0; blk < 6; blk++) begin
      send_gap_pct = (blk < 2) ? 38 : (blk < 4) ? 73 : 0;
      recv_gap_pct = (blk < 2) ? 73 : (blk < 4) ? 38 : 0;
      case (blk)
        0: set_mids(0, 0, 0, 0);
        1: set_mids(4095, 4095, 4095, 4095);
        2: set_mids($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                    $urandom_range(4095));
        3: set_mids(0, 4095, 0, 4095);
        4: set_mids(4095, 0, 4095, 0);
        default: set_mids(15, 4080, 2048, 1);
      endcase
      queue_walk(322);
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
